@@ hdl/ole_pkg.sv @@
// Types and codes shared by the ordered list engine.
package ole_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_DEL_HEAD   = 3'd3,
    OP_DEL_TAIL   = 3'd4,
    OP_DEL_KEY    = 3'd5,
    OP_DUMP_FWD   = 3'd6,
    OP_DUMP_REV   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_DONE
  } state_t;

endpackage

@@ hdl/ordered_list_engine.sv @@
// Top level of the ordered list engine: sequencer around node pool and allocator.
// Accepts one command when start is high and busy low, then stays busy until its
// results are out. Pushes wait for the free node scan, key operations walk the
// list one node per read and compare state pair through the single read port of
// the node memory, and dumps emit one result per read and output state pair.
// Results appear with strobe high for one cycle each and cannot be held off.
module ordered_list_engine #(
  parameter int DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ole_pkg::cmd_t cmd,
  output logic          busy,
  output logic          strobe,
  output ole_pkg::rsp_t result
);
  import ole_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;
  op_t    op;
  logic signed [31:0] val_q, key_q;
  logic [AW-1:0] head, tail, cur, hit, newn;
  logic [CW-1:0] count, idx;
  logic [1:0]    st_q;

  logic               rd_en_unused;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_value;
  logic [AW-1:0]      rd_next, rd_prev;
  logic               wv_en, wn_en, wp_en;
  logic [AW-1:0]      wv_a, wn_a, wn_d, wp_a, wp_d;

  logic          scan_start, scan_done, take, give;
  logic [AW-1:0] scan_node, give_node;

  assign rd_en_unused = 1'b0;

  ole_node_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .rd_addr(rd_addr), .rd_value(rd_value), .rd_next(rd_next),
    .rd_prev(rd_prev), .wr_val_en(wv_en), .wr_val_addr(wv_a), .wr_val(val_q),
    .wr_next_en(wn_en), .wr_next_addr(wn_a), .wr_next(wn_d),
    .wr_prev_en(wp_en), .wr_prev_addr(wp_a), .wr_prev(wp_d)
  );

  ole_free_alloc #(.DEPTH(DEPTH), .AW(AW)) u_alloc (
    .clk(clk), .rst(rst), .scan_start(scan_start), .scan_done(scan_done),
    .scan_node(scan_node), .take(take), .take_node(newn), .give(give),
    .give_node(give_node)
  );

  logic full, empty, is_tail_hit;
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign is_tail_hit = (hit == tail);
  assign rd_addr = cur;
  assign busy = (state != S_IDLE);

  // Sequence one command
  always_comb begin
    state_next = state;
    scan_start = 1'b0;
    case (state)
      S_IDLE: if (start) begin
        case (op_t'(cmd.mode))
          OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_AFTER: begin
            if (full) state_next = S_DONE;
            else if (op_t'(cmd.mode) == OP_INS_AFTER && !empty) state_next = S_SRCH_RD;
            else begin
              state_next = S_ALLOC;
              scan_start = 1'b1;
            end
          end
          OP_DEL_HEAD, OP_DEL_TAIL: state_next = empty ? S_DONE : S_DEL_RD;
          OP_DEL_KEY: state_next = empty ? S_DONE : S_SRCH_RD;
          default: state_next = empty ? S_DONE : S_DUMP_RD;
        endcase
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (rd_value == key_q) begin
          if (op == OP_INS_AFTER) begin
            state_next = S_ALLOC;
            scan_start = 1'b1;
          end else state_next = S_DEL_RD;
        end else if (idx + 1'b1 >= count) state_next = S_DONE;
        else state_next = S_SRCH_RD;
      end
      S_ALLOC: if (scan_done) begin
        state_next = (op == OP_INS_AFTER && !empty && !is_tail_hit) ? S_INS_RD : S_INS_WR;
      end
      S_INS_RD: state_next = S_INS_WR;
      S_INS_WR: state_next = S_DONE;
      S_DEL_RD: state_next = S_DEL_WR;
      S_DEL_WR: state_next = S_DONE;
      S_DUMP_RD: state_next = S_DUMP_OUT;
      S_DUMP_OUT: state_next = (idx + 1'b1 >= count) ? S_IDLE : S_DUMP_RD;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Node memory writes and free map updates
  logic ins_mid, ins_front, del_head, del_tail;
  assign ins_front = (op == OP_PUSH_FRONT);
  assign ins_mid   = (op == OP_INS_AFTER) && !empty && !is_tail_hit;
  assign del_head  = (op == OP_DEL_HEAD) || (op == OP_DEL_KEY && hit == head);
  assign del_tail  = (op == OP_DEL_TAIL) || (op == OP_DEL_KEY && hit == tail && !del_head);

  always_comb begin
    wv_en = 1'b0; wv_a = newn;
    wn_en = 1'b0; wn_a = newn; wn_d = head;
    wp_en = 1'b0; wp_a = newn; wp_d = tail;
    take = 1'b0; give = 1'b0; give_node = cur;
    if (state == S_INS_WR) begin
      wv_en = 1'b1;
      take  = 1'b1;
      if (ins_mid) begin
        // rd_next holds next of hit; link new node between hit and it
        wn_en = 1'b1; wn_a = hit; wn_d = newn;
        wp_en = 1'b1; wp_a = rd_next; wp_d = newn;
      end else if (!empty) begin
        if (ins_front) begin
          wn_en = 1'b1; wn_a = newn; wn_d = head;
          wp_en = 1'b1; wp_a = head; wp_d = newn;
        end else begin
          wp_en = 1'b1; wp_a = newn; wp_d = tail;
          wn_en = 1'b1; wn_a = tail; wn_d = newn;
        end
      end
    end else if (state == S_INS_RD) begin
      // write new node links; the neighbors follow in S_INS_WR
      wn_en = 1'b1; wn_a = newn; wn_d = rd_next;
      wp_en = 1'b1; wp_a = newn; wp_d = hit;
    end else if (state == S_DEL_WR) begin
      give = 1'b1;
      if (!del_head && !del_tail) begin
        wn_en = 1'b1; wn_a = rd_prev; wn_d = rd_next;
        wp_en = 1'b1; wp_a = rd_next; wp_d = rd_prev;
      end
    end
  end

  // Hold command, pointers and walk position, and register the results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          op    <= op_t'(cmd.mode);
          val_q <= cmd.value;
          key_q <= cmd.key;
          idx   <= '0;
          cur   <= (op_t'(cmd.mode) == OP_DEL_TAIL || op_t'(cmd.mode) == OP_DUMP_REV)
                   ? tail : head;
          hit   <= (op_t'(cmd.mode) == OP_DEL_TAIL) ? tail : head;
          if (op_t'(cmd.mode) == OP_PUSH_FRONT || op_t'(cmd.mode) == OP_PUSH_BACK
              || op_t'(cmd.mode) == OP_INS_AFTER)
            st_q <= full ? ST_FULL : ST_OK;
          else st_q <= empty ? ST_EMPTY : ST_OK;
        end
        S_SRCH_CMP: begin
          if (rd_value == key_q) hit <= cur;
          else if (idx + 1'b1 >= count) st_q <= ST_NOTFOUND;
          else begin
            idx <= idx + 1'b1;
            cur <= rd_next;
          end
        end
        S_ALLOC: if (scan_done) begin
          newn <= scan_node;
          cur  <= hit;
        end
        S_INS_WR: begin
          count <= count + 1'b1;
          if (empty) begin
            head <= newn;
            tail <= newn;
          end else if (ins_mid) begin
          end else if (ins_front) head <= newn;
          else tail <= newn;
        end
        S_DEL_WR: begin
          if (count == CW'(1)) begin
            head <= '0;
            tail <= '0;
          end else if (del_head) head <= rd_next;
          else if (del_tail) tail <= rd_prev;
          count <= count - 1'b1;
        end
        S_DUMP_OUT: begin
          strobe <= 1'b1;
          result.status <= ST_OK;
          result.data   <= rd_value;
          result.last   <= (idx + 1'b1 >= count);
          idx <= idx + 1'b1;
          cur <= (op == OP_DUMP_FWD) ? rd_next : rd_prev;
        end
        S_DONE: begin
          strobe <= 1'b1;
          result.status <= st_q;
          result.data   <= '0;
          result.last   <= 1'b1;
        end
        default: begin
        end
      endcase
      if (state == S_SRCH_CMP && rd_value == key_q && op == OP_DEL_KEY) cur <= cur;
      if (rd_en_unused) cur <= cur;
    end
  end
endmodule

@@ hdl/ole_free_alloc.sv @@
// Free node bitmap with a one-bit-per-cycle lowest free node scan.
module ole_free_alloc #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          scan_start,
  output logic          scan_done,
  output logic [AW-1:0] scan_node,
  input  logic          take,
  input  logic [AW-1:0] take_node,
  input  logic          give,
  input  logic [AW-1:0] give_node
);
  logic [DEPTH-1:0] free_map;
  logic [AW-1:0]    ptr;
  logic             scanning;

  // Update the map on take and give; walk it one node per cycle until a free node is found or the last node is reached
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      scanning <= 1'b0;
      ptr      <= '0;
    end else begin
      if (take) free_map[take_node] <= 1'b0;
      if (give) free_map[give_node] <= 1'b1;
      if (scan_start) begin
        scanning <= 1'b1;
        ptr      <= '0;
      end else if (scanning) begin
        if (free_map[ptr]) scanning <= 1'b0;
        else if (ptr != AW'(DEPTH - 1)) ptr <= ptr + 1'b1;
        else scanning <= 1'b0;
      end
    end
  end

  assign scan_done = scanning && (free_map[ptr] || ptr == AW'(DEPTH - 1));
  assign scan_node = ptr;
endmodule

@@ hdl/ole_node_mem.sv @@
// Node pool: value, next and prev link memories with registered reads.
module ole_node_mem #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic               clk,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [31:0] rd_value,
  output logic [AW-1:0]      rd_next,
  output logic [AW-1:0]      rd_prev,
  input  logic               wr_val_en,
  input  logic [AW-1:0]      wr_val_addr,
  input  logic signed [31:0] wr_val,
  input  logic               wr_next_en,
  input  logic [AW-1:0]      wr_next_addr,
  input  logic [AW-1:0]      wr_next,
  input  logic               wr_prev_en,
  input  logic [AW-1:0]      wr_prev_addr,
  input  logic [AW-1:0]      wr_prev
);
  logic signed [31:0] val_mem [DEPTH];
  logic [AW-1:0]      next_mem [DEPTH];
  logic [AW-1:0]      prev_mem [DEPTH];

  // Write each memory at one port, read all three at one address
  always_ff @(posedge clk) begin
    if (wr_val_en) val_mem[wr_val_addr] <= wr_val;
    if (wr_next_en) next_mem[wr_next_addr] <= wr_next;
    if (wr_prev_en) prev_mem[wr_prev_addr] <= wr_prev;
    rd_value <= val_mem[rd_addr];
    rd_next  <= next_mem[rd_addr];
    rd_prev  <= prev_mem[rd_addr];
  end
endmodule
